// ===== rtl/core/npmv_pkg.sv =====
// Package: constants, payload types and controller/datapath command types.
package npmv_pkg;

    localparam int NODES        = 8;
    localparam int MAX_PROBE_ID = 10;
    localparam int IDX_W        = 4;

    localparam logic [3:0] PH_DISCOVER      = 4'd0;
    localparam logic [3:0] PH_DISCOVER_WAIT = 4'd1;
    localparam logic [3:0] PH_POLL_READ     = 4'd2;
    localparam logic [3:0] PH_WAIT_READ     = 4'd3;
    localparam logic [3:0] PH_EVALUATE      = 4'd4;
    localparam logic [3:0] PH_POLL_WRITE    = 4'd5;
    localparam logic [3:0] PH_WAIT_WRITE    = 4'd6;
    localparam logic [3:0] PH_DELAY         = 4'd7;
    localparam logic [3:0] PH_ERROR         = 4'd8;

    localparam logic [2:0] RQ_NONE  = 3'd0;
    localparam logic [2:0] RQ_READ  = 3'd1;
    localparam logic [2:0] RQ_WRITE = 3'd2;
    localparam logic [2:0] RQ_STOP  = 3'd3;
    localparam logic [2:0] RQ_ABORT = 3'd4;

    localparam logic [2:0] K_TICK     = 3'd0;
    localparam logic [2:0] K_COMPLETE = 3'd1;
    localparam logic [2:0] K_ERROR    = 3'd2;
    localparam logic [2:0] K_SET_RUN  = 3'd3;
    localparam logic [2:0] K_WAKEUP   = 3'd4;

    localparam logic [2:0] R_STANDBY  = 3'd0;
    localparam logic [2:0] R_WAKEUP   = 3'd1;
    localparam logic [2:0] R_INV_TYPE = 3'd2;
    localparam logic [2:0] R_DISC_TO  = 3'd3;
    localparam logic [2:0] R_DELAY    = 3'd4;
    localparam logic [2:0] R_WISH_A   = 3'd5;
    localparam logic [2:0] R_PERM_A   = 3'd6;
    localparam logic [2:0] R_STOP_A   = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] wish;
        logic [15:0] emergency;
        logic [15:0] type_word;
        logic        run_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  request_kind;
        logic [3:0]  request_node;
        logic [15:0] request_register;
        logic [15:0] request_value;
        logic [15:0] system_mode;
        logic        run_enabled;
        logic [3:0]  node_count;
        logic [3:0]  phase;
    } out_item_t;

    typedef struct packed {
        logic vote_start;
        logic vote_step;
        logic store_probe;
        logic store_poll;
    } dp_cmd_t;

    typedef struct packed {
        logic            vote_last;
        logic [15:0]     voted_mode;
        logic            clear_wakeup;
        logic [IDX_W-1:0] node_id;
    } dp_status_t;

endpackage

// ===== rtl/core/npmv_datapath.sv =====
// Datapath: node tables and a one-entry-per-cycle vote scanner.
module npmv_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  npmv_pkg::dp_cmd_t               cmd,
    input  logic [npmv_pkg::IDX_W-1:0]      wr_index,
    input  logic [npmv_pkg::IDX_W-1:0]      rd_index,
    input  logic [npmv_pkg::IDX_W-1:0]      probe_id,
    input  logic [npmv_pkg::IDX_W-1:0]      found_count,
    input  logic [15:0]                     wish,
    input  logic [15:0]                     emergency,
    input  logic [15:0]                     type_word,
    input  logic [15:0]                     inverter_type_code,
    input  logic [15:0]                     standby_mode_code,
    input  logic [15:0]                     wakeup_mode_code,
    input  logic                            run_flag,
    input  logic                            wakeup_pending,
    output npmv_pkg::dp_status_t            status
);
    logic [npmv_pkg::IDX_W-1:0] id_reg   [npmv_pkg::NODES];
    logic [15:0]                wish_reg [npmv_pkg::NODES];
    logic [15:0]                emg_reg  [npmv_pkg::NODES];
    logic [15:0]                type_reg [npmv_pkg::NODES];

    logic [npmv_pkg::IDX_W-1:0] scan_reg, scan_next;
    logic emerg_reg, emerg_next, inv_reg, inv_next, same_reg, same_next;
    logic [15:0] inv_wish_reg, inv_wish_next;
    logic [npmv_pkg::IDX_W-1:0] n_lim;
    logic scan_ok;

    assign n_lim = (found_count < npmv_pkg::IDX_W'(npmv_pkg::NODES))
                   ? found_count : npmv_pkg::IDX_W'(npmv_pkg::NODES);
    assign scan_ok = scan_reg < n_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < npmv_pkg::NODES; i++)
            begin
                id_reg[i]   <= '0;
                wish_reg[i] <= '0;
                emg_reg[i]  <= '0;
                type_reg[i] <= '0;
            end
            scan_reg     <= '0;
            emerg_reg    <= 1'b0;
            inv_reg      <= 1'b0;
            same_reg     <= 1'b1;
            inv_wish_reg <= '0;
        end
        else
        begin
            if ((cmd.store_probe || cmd.store_poll) &&
                wr_index < npmv_pkg::IDX_W'(npmv_pkg::NODES))
            begin
                wish_reg[wr_index[2:0]] <= wish;
                emg_reg[wr_index[2:0]]  <= emergency;
                type_reg[wr_index[2:0]] <= type_word;
                if (cmd.store_probe)
                    id_reg[wr_index[2:0]] <= probe_id;
            end
            scan_reg     <= scan_next;
            emerg_reg    <= emerg_next;
            inv_reg      <= inv_next;
            same_reg     <= same_next;
            inv_wish_reg <= inv_wish_next;
        end
    end

    always_comb
    begin
        scan_next     = scan_reg;
        emerg_next    = emerg_reg;
        inv_next      = inv_reg;
        same_next     = same_reg;
        inv_wish_next = inv_wish_reg;
        if (cmd.vote_start)
        begin
            scan_next     = '0;
            emerg_next    = 1'b0;
            inv_next      = 1'b0;
            same_next     = 1'b1;
            inv_wish_next = '0;
        end
        else if (cmd.vote_step && scan_ok)
        begin
            if (emg_reg[scan_reg[2:0]] != 16'd0)
                emerg_next = 1'b1;
            if (type_reg[scan_reg[2:0]] == inverter_type_code)
            begin
                inv_next      = 1'b1;
                inv_wish_next = wish_reg[scan_reg[2:0]];
            end
            if (wish_reg[scan_reg[2:0]] != wish_reg[0])
                same_next = 1'b0;
            scan_next = scan_reg + npmv_pkg::IDX_W'(1);
        end
    end

    always_comb
    begin
        status.vote_last    = !scan_ok;
        status.clear_wakeup = 1'b0;
        if (emerg_reg || !run_flag)
            status.voted_mode = standby_mode_code;
        else if (wakeup_pending)
        begin
            status.voted_mode   = wakeup_mode_code;
            status.clear_wakeup = 1'b1;
        end
        else if (inv_reg)
            status.voted_mode = inv_wish_reg;
        else
            status.voted_mode = same_reg ? wish_reg[0] : standby_mode_code;
        status.node_id = (rd_index < npmv_pkg::IDX_W'(npmv_pkg::NODES))
                         ? id_reg[rd_index[2:0]] : '0;
    end
endmodule

// ===== rtl/core/npmv_controller.sv =====
// Controller: phase machine, counters, flags, handshake and result register.
module npmv_controller
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  npmv_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output npmv_pkg::out_item_t          out_data,
    input  logic [15:0]                  standby_mode_code,
    input  logic [15:0]                  discovery_timeout_ticks,
    input  logic [15:0]                  poll_delay_ticks,
    input  logic [15:0]                  wish_register_addr,
    input  logic [15:0]                  permission_register_addr,
    input  logic [15:0]                  safety_stop_register_addr,
    output npmv_pkg::dp_cmd_t            cmd,
    input  npmv_pkg::dp_status_t         status,
    output logic [npmv_pkg::IDX_W-1:0]   wr_index,
    output logic [npmv_pkg::IDX_W-1:0]   target_index,
    output logic [npmv_pkg::IDX_W-1:0]   probe_id,
    output logic [npmv_pkg::IDX_W-1:0]   found_count,
    output logic                         run_flag,
    output logic                         wakeup_pending
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_VOTE = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  st_reg, st_next;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  probe_reg, probe_next, found_reg, found_next, tgt_reg, tgt_next;
    logic [15:0] elapsed_reg, elapsed_next, mode_reg, mode_next, inc;
    logic        wait_reg, wait_next, run_reg, run_next, wake_reg, wake_next;
    npmv_pkg::out_item_t res_reg, res_next;
    logic [2:0]  rk;
    logic [3:0]  rn;
    logic [15:0] rr, rv;
    logic        take;

    assign take = in_valid && !in_stall;
    assign in_stall = (st_reg != S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign out_data = res_reg;
    assign probe_id = probe_reg;
    assign found_count = found_reg;
    assign target_index = tgt_reg;
    assign run_flag = run_reg;
    assign wakeup_pending = wake_reg;
    assign inc = (elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            phase_reg   <= npmv_pkg::PH_DISCOVER;
            probe_reg   <= 4'd1;
            found_reg   <= '0;
            tgt_reg     <= '0;
            elapsed_reg <= '0;
            wait_reg    <= 1'b0;
            mode_reg    <= '0;
            run_reg     <= 1'b0;
            wake_reg    <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            probe_reg   <= probe_next;
            found_reg   <= found_next;
            tgt_reg     <= tgt_next;
            elapsed_reg <= elapsed_next;
            wait_reg    <= wait_next;
            mode_reg    <= mode_next;
            run_reg     <= run_next;
            wake_reg    <= wake_next;
            res_reg     <= res_next;
        end
    end

    always_comb
    begin
        st_next      = st_reg;
        phase_next   = phase_reg;
        probe_next   = probe_reg;
        found_next   = found_reg;
        tgt_next     = tgt_reg;
        elapsed_next = elapsed_reg;
        wait_next    = wait_reg;
        mode_next    = mode_reg;
        run_next     = run_reg;
        wake_next    = wake_reg;
        res_next     = res_reg;
        cmd          = '0;
        wr_index     = found_reg;
        rk = npmv_pkg::RQ_NONE;
        rn = '0;
        rr = '0;
        rv = '0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    st_next = S_OUT;
                    case (in_data.kind)
                        npmv_pkg::K_TICK:
                        begin
                            case (phase_reg)
                                npmv_pkg::PH_DISCOVER:
                                begin
                                    rk = npmv_pkg::RQ_READ;
                                    rn = probe_reg;
                                    rr = wish_register_addr;
                                    rv = 16'd3;
                                    wait_next = 1'b1;
                                    elapsed_next = '0;
                                    phase_next = npmv_pkg::PH_DISCOVER_WAIT;
                                end
                                npmv_pkg::PH_DISCOVER_WAIT:
                                begin
                                    if (wait_reg)
                                    begin
                                        elapsed_next = inc;
                                        if (inc > discovery_timeout_ticks)
                                        begin
                                            rk = npmv_pkg::RQ_ABORT;
                                            rn = probe_reg;
                                            wait_next = 1'b0;
                                            if (probe_reg >= 4'(npmv_pkg::MAX_PROBE_ID))
                                            begin
                                                tgt_next = '0;
                                                elapsed_next = '0;
                                                phase_next = npmv_pkg::PH_DELAY;
                                            end
                                            else
                                            begin
                                                probe_next = probe_reg + 4'd1;
                                                phase_next = npmv_pkg::PH_DISCOVER;
                                            end
                                        end
                                    end
                                end
                                npmv_pkg::PH_POLL_READ:
                                begin
                                    if (found_reg != 4'd0)
                                    begin
                                        rk = npmv_pkg::RQ_READ;
                                        rn = status.node_id;
                                        rr = wish_register_addr;
                                        rv = 16'd3;
                                        phase_next = npmv_pkg::PH_WAIT_READ;
                                    end
                                    else
                                    begin
                                        elapsed_next = '0;
                                        phase_next = npmv_pkg::PH_DELAY;
                                    end
                                end
                                npmv_pkg::PH_EVALUATE:
                                begin
                                    cmd.vote_start = 1'b1;
                                    st_next = S_VOTE;
                                end
                                npmv_pkg::PH_POLL_WRITE:
                                begin
                                    if (found_reg != 4'd0)
                                    begin
                                        rk = npmv_pkg::RQ_WRITE;
                                        rn = status.node_id;
                                        rr = permission_register_addr;
                                        rv = mode_reg;
                                        phase_next = npmv_pkg::PH_WAIT_WRITE;
                                    end
                                end
                                npmv_pkg::PH_DELAY:
                                begin
                                    elapsed_next = inc;
                                    if (inc > poll_delay_ticks)
                                    begin
                                        tgt_next = '0;
                                        phase_next = npmv_pkg::PH_POLL_READ;
                                    end
                                end
                                npmv_pkg::PH_ERROR:
                                begin
                                    rk = npmv_pkg::RQ_STOP;
                                    rr = safety_stop_register_addr;
                                    rv = 16'd1;
                                    mode_next = standby_mode_code;
                                    elapsed_next = '0;
                                    tgt_next = '0;
                                    phase_next = npmv_pkg::PH_DELAY;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        npmv_pkg::K_COMPLETE:
                        begin
                            if (phase_reg == npmv_pkg::PH_DISCOVER_WAIT)
                            begin
                                if (found_reg < 4'(npmv_pkg::NODES))
                                begin
                                    cmd.store_probe = 1'b1;
                                    found_next = found_reg + 4'd1;
                                end
                                wait_next = 1'b0;
                                if (probe_reg >= 4'(npmv_pkg::MAX_PROBE_ID))
                                begin
                                    tgt_next = '0;
                                    elapsed_next = '0;
                                    phase_next = npmv_pkg::PH_DELAY;
                                end
                                else
                                begin
                                    probe_next = probe_reg + 4'd1;
                                    phase_next = npmv_pkg::PH_DISCOVER;
                                end
                            end
                            else if (phase_reg == npmv_pkg::PH_WAIT_READ)
                            begin
                                cmd.store_poll = 1'b1;
                                wr_index = tgt_reg;
                                tgt_next = tgt_reg + 4'd1;
                                phase_next = (tgt_next >= found_reg)
                                             ? npmv_pkg::PH_EVALUATE
                                             : npmv_pkg::PH_POLL_READ;
                            end
                            else if (phase_reg == npmv_pkg::PH_WAIT_WRITE)
                            begin
                                tgt_next = tgt_reg + 4'd1;
                                if (tgt_next >= found_reg)
                                begin
                                    elapsed_next = '0;
                                    phase_next = npmv_pkg::PH_DELAY;
                                end
                                else
                                    phase_next = npmv_pkg::PH_POLL_WRITE;
                            end
                        end
                        npmv_pkg::K_ERROR:
                        begin
                            if (phase_reg == npmv_pkg::PH_DISCOVER_WAIT)
                            begin
                                wait_next = 1'b0;
                                if (probe_reg >= 4'(npmv_pkg::MAX_PROBE_ID))
                                begin
                                    tgt_next = '0;
                                    elapsed_next = '0;
                                    phase_next = npmv_pkg::PH_DELAY;
                                end
                                else
                                begin
                                    probe_next = probe_reg + 4'd1;
                                    phase_next = npmv_pkg::PH_DISCOVER;
                                end
                            end
                            else
                                phase_next = npmv_pkg::PH_ERROR;
                        end
                        npmv_pkg::K_SET_RUN: run_next = in_data.run_value;
                        npmv_pkg::K_WAKEUP:  wake_next = 1'b1;
                        default:
                        begin
                        end
                    endcase
                    res_next = '{rk, rn, rr, rv, mode_next, run_next, found_next,
                                 phase_next};
                end
            end
            S_VOTE:
            begin
                cmd.vote_step = 1'b1;
                if (status.vote_last)
                begin
                    mode_next = status.voted_mode;
                    if (status.clear_wakeup)
                        wake_next = 1'b0;
                    tgt_next = '0;
                    phase_next = npmv_pkg::PH_POLL_WRITE;
                    st_next = S_OUT;
                    res_next = '{npmv_pkg::RQ_NONE, 4'd0, 16'd0, 16'd0, mode_next,
                                 run_reg, found_reg, phase_next};
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/node_poll_mode_voter_unit.sv =====
// Top level: node polling master with configuration registers.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall, in_data
//  out     | output    | out_valid / out_stall, out_data
//  cfg     | input     | cfg_valid / cfg_ready, cfg_index, cfg_data
// An item is taken only while idle and its result is held until taken; an
// evaluate tick adds a pass in which the vote scanner walks the tables one
// entry a cycle. Reset is asynchronous; tables clear at once. Input is
// stalled while a result waits.
module node_poll_mode_voter_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  npmv_pkg::in_item_t     in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output npmv_pkg::out_item_t    out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    logic [15:0] standby_reg, wakeup_reg, inv_reg, disc_reg, delay_reg;
    logic [15:0] wish_a_reg, perm_a_reg, stop_a_reg;
    npmv_pkg::dp_cmd_t    cmd;
    npmv_pkg::dp_status_t status;
    logic [npmv_pkg::IDX_W-1:0] wr_index, target_index, probe_id, found_count;
    logic run_flag, wakeup_pending;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            standby_reg <= 16'd0;
            wakeup_reg  <= 16'd3;
            inv_reg     <= 16'd1;
            disc_reg    <= 16'd150;
            delay_reg   <= 16'd100;
            wish_a_reg  <= 16'd0;
            perm_a_reg  <= 16'd3;
            stop_a_reg  <= 16'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                npmv_pkg::R_STANDBY:  standby_reg <= cfg_data;
                npmv_pkg::R_WAKEUP:   wakeup_reg  <= cfg_data;
                npmv_pkg::R_INV_TYPE: inv_reg     <= cfg_data;
                npmv_pkg::R_DISC_TO:  disc_reg    <= cfg_data;
                npmv_pkg::R_DELAY:    delay_reg   <= cfg_data;
                npmv_pkg::R_WISH_A:   wish_a_reg  <= cfg_data;
                npmv_pkg::R_PERM_A:   perm_a_reg  <= cfg_data;
                npmv_pkg::R_STOP_A:   stop_a_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    npmv_controller u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .standby_mode_code(standby_reg),
        .discovery_timeout_ticks(disc_reg),
        .poll_delay_ticks(delay_reg),
        .wish_register_addr(wish_a_reg),
        .permission_register_addr(perm_a_reg),
        .safety_stop_register_addr(stop_a_reg),
        .cmd(cmd), .status(status),
        .wr_index(wr_index), .target_index(target_index),
        .probe_id(probe_id), .found_count(found_count),
        .run_flag(run_flag), .wakeup_pending(wakeup_pending)
    );

    npmv_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .wr_index(wr_index), .rd_index(target_index),
        .probe_id(probe_id), .found_count(found_count),
        .wish(in_data.wish), .emergency(in_data.emergency),
        .type_word(in_data.type_word),
        .inverter_type_code(inv_reg),
        .standby_mode_code(standby_reg),
        .wakeup_mode_code(wakeup_reg),
        .run_flag(run_flag), .wakeup_pending(wakeup_pending),
        .status(status)
    );

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result waits");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_count <= 4'(npmv_pkg::NODES)) else $error("node count overflow");
    a_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store_probe && cmd.store_poll)) else $error("double table write");
endmodule

// ===== dv/node_poll_mode_voter_unit_tb.sv =====
// Testbench for the node polling mode voter: directed table, then random event streams.
`timescale 1ns / 1ps

module node_poll_mode_voter_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    npmv_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    npmv_pkg::out_item_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [15:0]          cfg_data;

    node_poll_mode_voter_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller shadow
    logic [15:0] m_standby, m_wakeup, m_inv_type, m_disc_to, m_delay;
    logic [15:0] m_wish_a, m_perm_a, m_stop_a;
    logic [3:0]  m_phase, m_probe, m_found, m_target;
    logic [15:0] m_elapsed;
    logic        m_probe_wait;
    logic [3:0]  m_ids [npmv_pkg::NODES];
    logic [15:0] m_wish [npmv_pkg::NODES];
    logic [15:0] m_emerg [npmv_pkg::NODES];
    logic [15:0] m_type [npmv_pkg::NODES];
    logic [15:0] m_mode;
    logic        m_run, m_wake_pend;

    npmv_pkg::out_item_t expected_q[$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          idle_cycles;
    int          polls_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    function automatic void shadow_reset();
        m_standby = 16'd0; m_wakeup = 16'd3; m_inv_type = 16'd1; m_disc_to = 16'd150;
        m_delay = 16'd100; m_wish_a = 16'd0; m_perm_a = 16'd3; m_stop_a = 16'd4;
        m_phase = npmv_pkg::PH_DISCOVER; m_probe = 4'd1; m_found = 4'd0; m_target = 4'd0;
        m_elapsed = 16'd0; m_probe_wait = 1'b0;
        for (int i = 0; i < npmv_pkg::NODES; i++)
        begin
            m_ids[i] = 4'd0; m_wish[i] = 16'd0; m_emerg[i] = 16'd0; m_type[i] = 16'd0;
        end
        m_mode = 16'd0; m_run = 1'b0; m_wake_pend = 1'b0;
    endfunction

    function automatic void shadow_config(input logic [2:0] idx, input logic [15:0] v);
        case (idx)
            npmv_pkg::R_STANDBY:  m_standby = v;
            npmv_pkg::R_WAKEUP:   m_wakeup = v;
            npmv_pkg::R_INV_TYPE: m_inv_type = v;
            npmv_pkg::R_DISC_TO:  m_disc_to = v;
            npmv_pkg::R_DELAY:    m_delay = v;
            npmv_pkg::R_WISH_A:   m_wish_a = v;
            npmv_pkg::R_PERM_A:   m_perm_a = v;
            default:              m_stop_a = v;
        endcase
    endfunction

    function automatic void advance_probe();
        m_probe_wait = 1'b0;
        if (m_probe + 4'd1 > npmv_pkg::MAX_PROBE_ID)
        begin
            m_target = 4'd0; m_elapsed = 16'd0; m_phase = npmv_pkg::PH_DELAY;
        end
        else
        begin
            m_probe = m_probe + 4'd1; m_phase = npmv_pkg::PH_DISCOVER;
        end
    endfunction

    function automatic void cast_vote();
        logic        emerg, inv, same;
        logic [15:0] inv_wish;
        int          n;
        emerg = 1'b0; inv = 1'b0; inv_wish = 16'd0; same = 1'b1;
        n = (m_found < npmv_pkg::NODES) ? m_found : npmv_pkg::NODES;
        for (int i = 0; i < n; i++)
        begin
            if (m_emerg[i] != 0) emerg = 1'b1;
            if (m_type[i] == m_inv_type)
            begin
                inv = 1'b1; inv_wish = m_wish[i];
            end
        end
        for (int i = 1; i < n; i++)
            if (m_wish[i] != m_wish[0]) same = 1'b0;
        if (emerg || !m_run)
            m_mode = m_standby;
        else if (m_wake_pend)
        begin
            m_mode = m_wakeup; m_wake_pend = 1'b0;
        end
        else if (inv)
            m_mode = inv_wish;
        else
            m_mode = same ? m_wish[0] : m_standby;
    endfunction

    function automatic npmv_pkg::out_item_t predict_request(input npmv_pkg::in_item_t it);
        npmv_pkg::out_item_t r;
        r = '0;
        case (it.kind)
            npmv_pkg::K_TICK:
                case (m_phase)
                    npmv_pkg::PH_DISCOVER:
                    begin
                        r.request_kind = npmv_pkg::RQ_READ; r.request_node = m_probe;
                        r.request_register = m_wish_a; r.request_value = 16'd3;
                        m_probe_wait = 1'b1; m_elapsed = 16'd0;
                        m_phase = npmv_pkg::PH_DISCOVER_WAIT;
                    end
                    npmv_pkg::PH_DISCOVER_WAIT:
                        if (m_probe_wait)
                        begin
                            if (m_elapsed != 16'hFFFF) m_elapsed++;
                            if (m_elapsed > m_disc_to)
                            begin
                                r.request_kind = npmv_pkg::RQ_ABORT;
                                r.request_node = m_probe;
                                advance_probe();
                            end
                        end
                    npmv_pkg::PH_POLL_READ:
                        if (m_found > 0)
                        begin
                            r.request_kind = npmv_pkg::RQ_READ;
                            r.request_node = (m_target < npmv_pkg::NODES)
                                             ? m_ids[m_target] : 4'd0;
                            r.request_register = m_wish_a; r.request_value = 16'd3;
                            m_phase = npmv_pkg::PH_WAIT_READ;
                        end
                        else
                        begin
                            m_elapsed = 16'd0; m_phase = npmv_pkg::PH_DELAY;
                        end
                    npmv_pkg::PH_EVALUATE:
                    begin
                        cast_vote(); m_target = 4'd0; m_phase = npmv_pkg::PH_POLL_WRITE;
                        polls_done++;
                    end
                    npmv_pkg::PH_POLL_WRITE:
                        if (m_found > 0)
                        begin
                            r.request_kind = npmv_pkg::RQ_WRITE;
                            r.request_node = (m_target < npmv_pkg::NODES)
                                             ? m_ids[m_target] : 4'd0;
                            r.request_register = m_perm_a; r.request_value = m_mode;
                            m_phase = npmv_pkg::PH_WAIT_WRITE;
                        end
                    npmv_pkg::PH_DELAY:
                    begin
                        if (m_elapsed != 16'hFFFF) m_elapsed++;
                        if (m_elapsed > m_delay)
                        begin
                            m_target = 4'd0; m_phase = npmv_pkg::PH_POLL_READ;
                        end
                    end
                    npmv_pkg::PH_ERROR:
                    begin
                        r.request_kind = npmv_pkg::RQ_STOP; r.request_register = m_stop_a;
                        r.request_value = 16'd1; m_mode = m_standby; m_elapsed = 16'd0;
                        m_target = 4'd0; m_phase = npmv_pkg::PH_DELAY;
                    end
                    default: ;
                endcase
            npmv_pkg::K_COMPLETE:
                if (m_phase == npmv_pkg::PH_DISCOVER_WAIT)
                begin
                    if (m_found < npmv_pkg::NODES)
                    begin
                        m_ids[m_found] = m_probe; m_wish[m_found] = it.wish;
                        m_emerg[m_found] = it.emergency; m_type[m_found] = it.type_word;
                        m_found++;
                    end
                    advance_probe();
                end
                else if (m_phase == npmv_pkg::PH_WAIT_READ)
                begin
                    if (m_target < npmv_pkg::NODES)
                    begin
                        m_wish[m_target] = it.wish; m_emerg[m_target] = it.emergency;
                        m_type[m_target] = it.type_word;
                    end
                    m_target++;
                    m_phase = (m_target >= m_found) ? npmv_pkg::PH_EVALUATE
                                                    : npmv_pkg::PH_POLL_READ;
                end
                else if (m_phase == npmv_pkg::PH_WAIT_WRITE)
                begin
                    m_target++;
                    if (m_target >= m_found)
                    begin
                        m_elapsed = 16'd0; m_phase = npmv_pkg::PH_DELAY;
                    end
                    else
                        m_phase = npmv_pkg::PH_POLL_WRITE;
                end
            npmv_pkg::K_ERROR:
                if (m_phase == npmv_pkg::PH_DISCOVER_WAIT) advance_probe();
                else m_phase = npmv_pkg::PH_ERROR;
            npmv_pkg::K_SET_RUN: m_run = it.run_value;
            npmv_pkg::K_WAKEUP:  m_wake_pend = 1'b1;
            default: ;
        endcase
        r.system_mode = m_mode; r.run_enabled = m_run;
        r.node_count = m_found; r.phase = m_phase;
        return r;
    endfunction

    // sender: bursts and gaps
    task automatic send_event(input npmv_pkg::in_item_t it);
        if (($urandom_range(0, 5) == 0) && (items_sent % 40 > 20))
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_q.push_back(predict_request(it));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        in_data  <= '0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (npmv_pkg::NODES + 8) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_config(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic npmv_pkg::in_item_t make_event(input logic [2:0] k,
                                                      input logic [15:0] w,
                                                      input logic [15:0] e,
                                                      input logic [15:0] t,
                                                      input logic rv);
        npmv_pkg::in_item_t it;
        it.kind = k; it.wish = w; it.emergency = e; it.type_word = t; it.run_value = rv;
        return it;
    endfunction

    function automatic npmv_pkg::in_item_t random_event();
        npmv_pkg::in_item_t it;
        int       sel;
        it = '0;
        it.wish = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
        it.emergency = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0;
        it.type_word = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 2));
        it.run_value = ($urandom_range(0, 4) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 55)      it.kind = npmv_pkg::K_TICK;
        else if (sel < 85) it.kind = npmv_pkg::K_COMPLETE;
        else if (sel < 90) it.kind = npmv_pkg::K_ERROR;
        else if (sel < 95) it.kind = npmv_pkg::K_SET_RUN;
        else if (sel < 98) it.kind = npmv_pkg::K_WAKEUP;
        else               it.kind = 3'($urandom_range(5, 7));
        // answers mostly arrive when a request is outstanding
        if ((m_phase == npmv_pkg::PH_DISCOVER_WAIT || m_phase == npmv_pkg::PH_WAIT_READ ||
             m_phase == npmv_pkg::PH_WAIT_WRITE) && $urandom_range(0, 2) != 0)
            it.kind = npmv_pkg::K_COMPLETE;
        return it;
    endfunction

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if ((results_seen / 64) % 3 == 2)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        npmv_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 16'd1, 16'd0);
            else
            begin
                want = expected_q.pop_front();
                if (out_data.request_kind != want.request_kind)
                    report_mismatch("request_kind", out_data.request_kind, want.request_kind);
                if (out_data.request_node != want.request_node)
                    report_mismatch("request_node", out_data.request_node, want.request_node);
                if (out_data.request_register != want.request_register)
                    report_mismatch("request_register", out_data.request_register,
                                    want.request_register);
                if (out_data.request_value != want.request_value)
                    report_mismatch("request_value", out_data.request_value,
                                    want.request_value);
                if (out_data.system_mode != want.system_mode)
                    report_mismatch("system_mode", out_data.system_mode, want.system_mode);
                if (out_data.run_enabled != want.run_enabled)
                    report_mismatch("run_enabled", out_data.run_enabled, want.run_enabled);
                if (out_data.node_count != want.node_count)
                    report_mismatch("node_count", out_data.node_count, want.node_count);
                if (out_data.phase != want.phase)
                    report_mismatch("phase", out_data.phase, want.phase);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("node_poll_mode_voter_unit_tb failed");
            $finish;
        end
    end

    typedef struct {
        npmv_pkg::in_item_t  ev;
        logic                typed;
        npmv_pkg::out_item_t want;
    } step_row_t;

    step_row_t directed[$];

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++)
            send_event(random_event());
    endtask

    initial
    begin
        npmv_pkg::out_item_t got_want;
        step_row_t row;
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; items_sent = 0; results_seen = 0; idle_cycles = 0; polls_done = 0;
        shadow_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_register(npmv_pkg::R_DISC_TO, 16'd1);
        write_register(npmv_pkg::R_DELAY, 16'd0);

        // first probe: read of id 1, typed in
        row.ev = make_event(npmv_pkg::K_TICK, '0, '0, '0, 1'b0); row.typed = 1'b1;
        row.want = '{npmv_pkg::RQ_READ, 4'd1, 16'd0, 16'd3, 16'd0, 1'b0, 4'd0,
                     npmv_pkg::PH_DISCOVER_WAIT};
        directed.push_back(row);
        row.typed = 1'b0;
        row.ev = make_event(npmv_pkg::K_COMPLETE, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        directed.push_back(row);
        row.ev = make_event(npmv_pkg::K_TICK, '0, '0, '0, 1'b0); directed.push_back(row);
        row.ev = make_event(npmv_pkg::K_ERROR, '0, '0, '0, 1'b0); directed.push_back(row);
        for (int i = 0; i < 9; i++)
        begin
            row.ev = make_event(npmv_pkg::K_TICK, '0, '0, '0, 1'b0); directed.push_back(row);
            row.ev = make_event(npmv_pkg::K_COMPLETE, 16'd2, 16'd0, 16'd0, 1'b1);
            directed.push_back(row);
        end
        row.ev = make_event(npmv_pkg::K_SET_RUN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        directed.push_back(row);
        row.ev = make_event(npmv_pkg::K_WAKEUP, '0, '0, '0, 1'b0); directed.push_back(row);
        row.ev = make_event(3'd7, '0, '0, '0, 1'b0); directed.push_back(row);
        row.ev = make_event(npmv_pkg::K_ERROR, '0, '0, '0, 1'b0); directed.push_back(row);
        row.ev = make_event(npmv_pkg::K_TICK, '0, '0, '0, 1'b0); directed.push_back(row);

        foreach (directed[i])
        begin
            send_event(directed[i].ev);
            if (directed[i].typed)
            begin
                got_want = expected_q[expected_q.size() - 1];
                if (got_want != directed[i].want)
                    report_mismatch("typed row", 16'(i), 16'(i));
            end
        end

        run_phase(300);
        drain_results();
        write_register(npmv_pkg::R_STANDBY, 16'hFFFF);
        write_register(npmv_pkg::R_WAKEUP, 16'h0000);
        write_register(npmv_pkg::R_INV_TYPE, 16'hFFFF);
        write_register(npmv_pkg::R_DELAY, 16'd3);
        write_register(npmv_pkg::R_WISH_A, 16'hFFFF);
        write_register(npmv_pkg::R_PERM_A, 16'h0000);
        write_register(npmv_pkg::R_STOP_A, 16'hFFFF);
        run_phase(350);
        drain_results();
        write_register(npmv_pkg::R_STANDBY, 16'h5A5A);
        write_register(npmv_pkg::R_WAKEUP, 16'hFFFF);
        write_register(npmv_pkg::R_INV_TYPE, 16'd0);
        write_register(npmv_pkg::R_DISC_TO, 16'hFFFF);
        write_register(npmv_pkg::R_DELAY, 16'hFFFF);
        write_register(npmv_pkg::R_PERM_A, 16'hFFFF);
        run_phase(300);
        drain_results();
        write_register(npmv_pkg::R_DISC_TO, 16'd2);
        write_register(npmv_pkg::R_DELAY, 16'd1);
        write_register(npmv_pkg::R_INV_TYPE, 16'd1);
        write_register(npmv_pkg::R_WISH_A, 16'd0);
        run_phase(470);
        drain_results();

        $display("sent %0d events, checked %0d results, %0d vote rounds, nodes found %0d",
                 items_sent, results_seen, polls_done, m_found);
        if (errors == 0)
            $display("node_poll_mode_voter_unit_tb passed");
        else
            $display("node_poll_mode_voter_unit_tb failed");
        $finish;
    end

endmodule
